FILE: src/cse_pkg.sv
// shared types, constants and character helpers for the string escape encoder
`timescale 1ns / 1ps

package cse_pkg;

    // widths fixed by the interface
    localparam int CFG_W    = 16;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int PIECE_N  = 4;
    localparam int LEN_W    = 3;
    localparam int POS_W    = 3;

    // default width of the remaining-space tracker
    localparam int DEF_CAPACITY_BITS = 16;

    // register reset and limits
    localparam logic [CFG_W-1:0]   CAP_RESET = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam int                 MIN_SPACE = 3;

    // characters used by the encoder
    localparam logic [CHAR_W-1:0] CHAR_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;
    localparam logic [CHAR_W-1:0] PRINT_LO    = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI    = 8'h7E;

    // input item
    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              end_of_string;
    } cse_in_t;

    // result item
    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               last_of_run;
        logic               string_done;
        logic               overflow;
        logic [COUNT_W-1:0] char_count;
    } cse_out_t;

    // classified work for one input item
    typedef struct packed {
        logic                            lead_quote;  // opening quote goes first
        logic                            lead_ovf;    // overflow result goes first
        logic                            main_ovf;    // main part is one overflow result
        logic                            done;        // main part closes the string
        logic [LEN_W-1:0]                len;         // characters in the main piece
        logic [PIECE_N-1:0][CHAR_W-1:0]  chars;       // main piece, first char at index 0
    } cse_job_t;

    // letter of a two-character escape, zero when the byte has none
    function automatic logic [CHAR_W-1:0] short_escape(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        unique case (c)
            8'h07:   r = 8'h61; // a
            8'h08:   r = 8'h62; // b
            8'h0C:   r = 8'h66; // f
            8'h0A:   r = 8'h6E; // n
            8'h0D:   r = 8'h72; // r
            8'h09:   r = 8'h74; // t
            8'h0B:   r = 8'h76; // v
            8'h5C:   r = CHAR_BSLASH;
            8'h22:   r = CHAR_QUOTE;
            default: r = CHAR_NONE;
        endcase
        return r;
    endfunction

    // lowercase hex digit
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'd0, d};
        else
            r = 8'h57 + {4'd0, d};
        return r;
    endfunction

endpackage

FILE: src/cse_front.sv
// front end: takes items, tracks quote, space and overflow state, builds jobs
`timescale 1ns / 1ps

module cse_front
    import cse_pkg::*;
#(
    parameter int CAPACITY_BITS = DEF_CAPACITY_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  cse_in_t          item,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             job_valid,
    input  logic             job_ready,
    output cse_job_t         job
);

    localparam int CB    = CAPACITY_BITS;
    localparam int EXT_W = (CB > CFG_W) ? CB : CFG_W;
    localparam int CMP_W = (CB > LEN_W) ? CB : LEN_W;
    localparam logic [EXT_W-1:0] RST_EXT = EXT_W'(CAP_RESET);

    logic [CFG_W-1:0] cap_reg;
    logic [CB-1:0]    space_reg, space_next;
    logic             opened_reg, opened_next;
    logic             ovf_reg, ovf_next;

    logic [EXT_W-1:0] cap_ext, cfg_ext;
    logic [CMP_W-1:0] space_w, sp_eff_w, sp_rem_w;
    logic [CHAR_W-1:0] esc;
    logic [LEN_W-1:0]  piece_len;
    logic [PIECE_N-1:0][CHAR_W-1:0] piece;
    logic              open_now, low_space, fit, close_fit, take;

    assign take       = item_valid && item_ready;
    assign item_ready = job_ready;
    assign job_valid  = item_valid;

    // capacity reload values
    assign cap_ext = EXT_W'(cap_reg);
    assign cfg_ext = EXT_W'(cfg_data);

    // piece for one byte
    always_comb
    begin
        esc   = short_escape(item.char_byte);
        piece = '0;
        if (esc != CHAR_NONE)
        begin
            piece[0]  = CHAR_BSLASH;
            piece[1]  = esc;
            piece_len = LEN_W'(2);
        end
        else if (item.char_byte >= PRINT_LO && item.char_byte <= PRINT_HI)
        begin
            piece[0]  = item.char_byte;
            piece_len = LEN_W'(1);
        end
        else
        begin
            piece[0]  = CHAR_BSLASH;
            piece[1]  = CHAR_X;
            piece[2]  = hex_digit(item.char_byte[7:4]);
            piece[3]  = hex_digit(item.char_byte[3:0]);
            piece_len = LEN_W'(4);
        end
    end

    // space checks
    assign open_now  = !opened_reg;
    assign space_w   = CMP_W'(space_reg);
    assign low_space = space_w < CMP_W'(MIN_SPACE);
    assign sp_eff_w  = open_now ? (space_w - CMP_W'(1)) : space_w;
    assign fit       = CMP_W'(piece_len) < sp_eff_w;
    assign close_fit = CMP_W'(1) < sp_eff_w;
    assign sp_rem_w  = sp_eff_w - CMP_W'(piece_len);

    // job and next state
    always_comb
    begin
        job         = '0;
        space_next  = space_reg;
        opened_next = opened_reg;
        ovf_next    = ovf_reg;
        if (item.end_of_string)
        begin
            job.done = 1'b1;
            if (ovf_reg)
                job.main_ovf = 1'b1;
            else if (open_now && low_space)
            begin
                job.lead_ovf = 1'b1;
                job.main_ovf = 1'b1;
            end
            else
            begin
                job.lead_quote = open_now;
                if (close_fit)
                begin
                    job.chars[0] = CHAR_QUOTE;
                    job.len      = LEN_W'(1);
                end
                else
                    job.main_ovf = 1'b1;
            end
            space_next  = cap_ext[CB-1:0];
            opened_next = 1'b0;
            ovf_next    = 1'b0;
        end
        else if (ovf_reg)
            job.main_ovf = 1'b1;
        else if (open_now && low_space)
        begin
            job.main_ovf = 1'b1;
            ovf_next     = 1'b1;
        end
        else
        begin
            job.lead_quote = open_now;
            opened_next    = 1'b1;
            if (fit)
            begin
                job.chars  = piece;
                job.len    = piece_len;
                space_next = sp_rem_w[CB-1:0];
            end
            else
            begin
                job.main_ovf = 1'b1;
                ovf_next     = 1'b1;
                space_next   = sp_eff_w[CB-1:0];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            space_reg  <= RST_EXT[CB-1:0];
            opened_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            cap_reg   <= cfg_data;
            space_reg <= cfg_ext[CB-1:0];
        end
        else if (take)
        begin
            space_reg  <= space_next;
            opened_reg <= opened_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

FILE: src/cse_fifo.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps

module cse_fifo
    import cse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  cse_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output cse_job_t pop_job
);

    cse_job_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

FILE: src/cse_back.sv
// back end: steps each job into the output reg one result per cycle unless stalled
`timescale 1ns / 1ps

module cse_back
    import cse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  cse_job_t job,
    output logic     result_valid,
    input  logic     result_ready,
    output cse_out_t result
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg;
    cse_out_t           out_reg, res_next;

    logic               has_lead, is_lead, is_last, issue, res_ovf;
    logic [POS_W-1:0]   total, idx;
    logic [COUNT_W-1:0] cnt_inc;

    assign issue = job_valid && (!out_valid_reg || result_ready);

    // position within the job
    assign has_lead = job.lead_quote || job.lead_ovf;
    assign total    = POS_W'(has_lead) + (job.main_ovf ? POS_W'(1) : POS_W'(job.len));
    assign is_lead  = has_lead && (pos_reg == '0);
    assign is_last  = (pos_reg == total - POS_W'(1));
    assign idx      = pos_reg - POS_W'(has_lead);
    assign res_ovf  = is_lead ? job.lead_ovf : job.main_ovf;

    // saturating running count
    assign cnt_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    // build the next result
    always_comb
    begin
        res_next.overflow    = res_ovf;
        res_next.last_of_run = is_last;
        res_next.string_done = is_last && job.done;
        res_next.char_count  = res_ovf ? count_reg : cnt_inc;
        if (res_ovf)
            res_next.out_char = CHAR_NONE;
        else if (is_lead)
            res_next.out_char = CHAR_QUOTE;
        else
            res_next.out_char = job.chars[idx[1:0]];
        pos_next   = is_last ? '0 : pos_reg + POS_W'(1);
        count_next = res_next.string_done ? '0 : res_next.char_count;
    end

    assign job_ready    = issue && is_last;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                pos_reg       <= pos_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (issue)
            out_reg <= res_next;
    end

    // a job never holds more than five results
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg < POS_W'(5))
        else $error("sequencer position out of range");

    // a closing result is always the last of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.string_done |-> out_reg.last_of_run)
        else $error("string_done without last_of_run");

    // overflow results carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.overflow |-> out_reg.out_char == CHAR_NONE)
        else $error("overflow result with a character");

    // the count restarts after a closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        issue && res_next.string_done |=> count_reg == '0)
        else $error("count not cleared after string end");

endmodule

FILE: src/c_string_escape_encoder.sv
// top level of the C string literal escape encoder
`timescale 1ns / 1ps

// Takes a string one byte per item and returns its C string literal form one
// character per result item, with opening and closing quotes, two-character
// escapes and \xhh for non-printable bytes. Each input item yields one to five
// results; the output side delivers one result per cycle while result_ready is
// held high, paced by the back-end sequencer feeding the output register. The
// front end classifies an item in the cycle it is accepted and queues it in a
// two-entry job queue, so input items keep flowing while earlier results drain.
// Writing cfg_data sets the destination size (including the NUL slot) and
// reloads the remaining space; write it only while the block is idle.

module c_string_escape_encoder
    import cse_pkg::*;
#(
    parameter int CAPACITY_BITS = DEF_CAPACITY_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  cse_in_t          item,
    output logic             result_valid,
    input  logic             result_ready,
    output cse_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic     fq_push_valid, fq_push_ready;
    cse_job_t fq_push_job;
    logic     fq_pop_valid, fq_pop_ready;
    cse_job_t fq_pop_job;

    // configuration always taken
    assign cfg_ready = 1'b1;

    // front end
    cse_front #(
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .job_valid  (fq_push_valid),
        .job_ready  (fq_push_ready),
        .job        (fq_push_job)
    );

    // job queue
    cse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_push_valid),
        .push_ready (fq_push_ready),
        .push_job   (fq_push_job),
        .pop_valid  (fq_pop_valid),
        .pop_ready  (fq_pop_ready),
        .pop_job    (fq_pop_job)
    );

    // back end
    cse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (fq_pop_valid),
        .job_ready    (fq_pop_ready),
        .job          (fq_pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
